FILE: rtl/vnorm_pkg.sv
// Shared types and constants for the vector normalization unit.
package vnorm_pkg;

   // Number of vector axes handled side by side.
   localparam int AXES = 3;
   // Output component width.
   localparam int OUT_BITS = 16;

   // Control carried with each pipeline stage.
   typedef struct packed {
      logic valid;
      logic zero;
   } stage_ctl_type;

endpackage

FILE: rtl/vnorm_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module vnorm_sqrt #(
   parameter int IN_BITS  = 34,
   parameter int ROOT_BITS = 17,
   parameter int TAG_BITS = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic [IN_BITS-1:0]    radicand,
   input  logic [TAG_BITS-1:0]   in_tag,
   output logic                  out_valid,
   output logic [ROOT_BITS-1:0]  root,
   output logic [TAG_BITS-1:0]   out_tag
);

   localparam int RB = 2 * ROOT_BITS;
   localparam int RM = ROOT_BITS + 2;

   logic [RB-1:0]        rad_ff [1:ROOT_BITS];
   logic [RM-1:0]        rem_ff [1:ROOT_BITS];
   logic [ROOT_BITS-1:0] q_ff   [1:ROOT_BITS];
   logic [TAG_BITS-1:0]  tag_ff [1:ROOT_BITS];
   logic [ROOT_BITS:1]   vld_ff;

   // Restoring root stages, two radicand bits consumed per stage.
   for (genvar s = 0; s < ROOT_BITS; s++) begin : g_stage
      logic [RB-1:0]        rad_cur;
      logic [RM-1:0]        rem_cur;
      logic [ROOT_BITS-1:0] q_cur;
      logic [TAG_BITS-1:0]  tag_cur;
      logic                 vld_cur;
      logic [RM-1:0]        rem_in;
      logic [RM-1:0]        trial;
      logic [ROOT_BITS-1:0] q_in;

      // First stage starts from the radicand with an empty remainder.
      if (s == 0) begin : g_head
         assign rad_cur = RB'(radicand);
         assign rem_cur = '0;
         assign q_cur   = '0;
         assign tag_cur = in_tag;
         assign vld_cur = in_valid;
      end else begin : g_body
         assign rad_cur = rad_ff[s];
         assign rem_cur = rem_ff[s];
         assign q_cur   = q_ff[s];
         assign tag_cur = tag_ff[s];
         assign vld_cur = vld_ff[s];
      end

      always_comb begin
         rem_in = {rem_cur[RM-3:0], rad_cur[RB-1 -: 2]};
         trial  = {q_cur, 2'b01};
         if (rem_in >= trial) begin
            rem_in = rem_in - trial;
            q_in   = {q_cur[ROOT_BITS-2:0], 1'b1};
         end else begin
            q_in   = {q_cur[ROOT_BITS-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[s+1] <= vld_cur;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[s+1] <= {rad_cur[RB-3:0], 2'b00};
            rem_ff[s+1] <= rem_in;
            q_ff[s+1]   <= q_in;
            tag_ff[s+1] <= tag_cur;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_BITS];
   assign root      = q_ff[ROOT_BITS];
   assign out_tag   = tag_ff[ROOT_BITS];

endmodule

FILE: rtl/vnorm_div.sv
// One division lane: pipelined restoring divide of a scaled magnitude by the norm.
module vnorm_div #(
   parameter int NUM_BITS = 30,
   parameter int DEN_BITS = 17
) (
   input  logic                 clock,
   input  logic                 adv,
   input  logic [NUM_BITS-1:0]  dividend,
   input  logic [DEN_BITS-1:0]  divisor,
   input  logic                 negate,
   output logic [NUM_BITS-1:0]  quotient,
   output logic                 neg_out
);

   logic [NUM_BITS-1:0] num_ff [1:NUM_BITS];
   logic [DEN_BITS:0]   rem_ff [1:NUM_BITS];
   logic [DEN_BITS-1:0] den_ff [1:NUM_BITS];
   logic                neg_ff [1:NUM_BITS];

   // One quotient bit per stage; quotient bits shift into the dividend word.
   for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
      logic [NUM_BITS-1:0] num_cur;
      logic [DEN_BITS:0]   rem_cur;
      logic [DEN_BITS-1:0] den_cur;
      logic                neg_cur;
      logic [DEN_BITS+1:0] part;
      logic                take;

      // First stage starts from the operands with an empty remainder.
      if (s == 0) begin : g_head
         assign num_cur = dividend;
         assign rem_cur = '0;
         assign den_cur = divisor;
         assign neg_cur = negate;
      end else begin : g_body
         assign num_cur = num_ff[s];
         assign rem_cur = rem_ff[s];
         assign den_cur = den_ff[s];
         assign neg_cur = neg_ff[s];
      end

      always_comb begin
         part = {rem_cur, num_cur[NUM_BITS-1]};
         take = part >= {2'b00, den_cur};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[s+1] <= take ? (DEN_BITS+1)'(part - {2'b00, den_cur})
                                : (DEN_BITS+1)'(part);
            num_ff[s+1] <= {num_cur[NUM_BITS-2:0], take};
            den_ff[s+1] <= den_cur;
            neg_ff[s+1] <= neg_cur;
         end
      end
   end

   assign quotient = num_ff[NUM_BITS];
   assign neg_out  = neg_ff[NUM_BITS];

endmodule

FILE: rtl/vector3_normalise_unit.sv
// Top level of the three-axis vector normalization unit.
// Usage:
//   req_ carries one sample vector per transaction; rsp_ returns its unit
//   vector in signed fixed point with FRACTION_BITS fraction bits.
//   Work flows through a square stage, a root pipeline of SAMPLE_BITS+1
//   stages, three division lanes of SAMPLE_BITS+FRACTION_BITS stages, and a
//   merging output register. Throughput is one vector per cycle while the
//   receiver does not stall; each stage holds one transaction.
//   An all-zero vector yields an all-zero result.
//   When the receiver stalls, the whole pipeline holds (req_tready falls
//   only while the output register is full and not taken), so no
//   transaction is lost.
//   Reset clears all valid flags; payload registers are not reset.
//   Results wider than 16 bits are wrapped to the output field.
module vector3_normalise_unit #(
   parameter int SAMPLE_BITS   = 16,
   parameter int FRACTION_BITS = 14
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // sample_x, sample_y, sample_z from bit 0 up
   input  logic [3*SAMPLE_BITS-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // unit_x, unit_y, unit_z from bit 0 up
   output logic [47:0]             rsp_tdata
);

   localparam int AX   = vnorm_pkg::AXES;
   localparam int OB   = vnorm_pkg::OUT_BITS;
   localparam int MB   = SAMPLE_BITS;
   localparam int SB   = 2 * MB + 2;
   localparam int RTB  = MB + 1;
   localparam int NB   = MB + FRACTION_BITS;
   localparam int TAGB = AX * (MB + 1) + 1;

   logic adv;
   logic out_full_ff;

   // Pipeline advances unless the result register is full and stalled.
   assign adv        = !out_full_ff || rsp_tready;
   assign req_tready = adv;

   // Magnitude and sign per axis, then squares.
   logic [MB-1:0]   mag_in [AX];
   logic [AX-1:0]   neg_in;
   logic [MB-1:0]   mag_ff [AX];
   logic [AX-1:0]   neg_ff;
   logic [2*MB-1:0] sq_ff  [AX];
   logic            s0_valid_ff;

   for (genvar k = 0; k < AX; k++) begin : g_mag
      logic [MB-1:0] raw;
      assign raw       = req_tdata[k*MB +: MB];
      assign neg_in[k] = raw[MB-1];
      assign mag_in[k] = raw[MB-1] ? MB'(~raw + 1'b1) : raw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         neg_ff     <= neg_in;
         for (int k = 0; k < AX; k++) begin
            mag_ff[k] <= mag_in[k];
            sq_ff[k]  <= mag_in[k] * mag_in[k];
         end
      end
   end

   // Sum of squares; zero flag, signs and magnitudes travel as the root tag.
   logic [SB-1:0]   sum;
   logic [TAGB-1:0] tag_in;
   logic [TAGB-1:0] tag_out;
   logic            root_valid;
   logic [RTB-1:0]  root;

   assign sum = SB'(sq_ff[0]) + SB'(sq_ff[1]) + SB'(sq_ff[2]);

   always_comb begin
      tag_in = '0;
      for (int k = 0; k < AX; k++) begin
         tag_in[k*(MB+1) +: MB+1] = {neg_ff[k], mag_ff[k]};
      end
      tag_in[TAGB-1] = (sum == '0);
   end

   vnorm_sqrt #(
      .IN_BITS  (SB),
      .ROOT_BITS(RTB),
      .TAG_BITS (TAGB)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (s0_valid_ff),
      .radicand (sum),
      .in_tag   (tag_in),
      .out_valid(root_valid),
      .root     (root),
      .out_tag  (tag_out)
   );

   // Division lanes, one per axis; valid and zero flag run alongside.
   logic [NB-1:0] quo   [AX];
   logic [AX-1:0] neg_q;
   vnorm_pkg::stage_ctl_type dv_ff [1:NB];

   for (genvar s = 0; s < NB; s++) begin : g_ctl
      vnorm_pkg::stage_ctl_type ctl;
      if (s == 0) begin : g_head
         assign ctl = '{valid: root_valid, zero: tag_out[TAGB-1]};
      end else begin : g_body
         assign ctl = dv_ff[s];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[s+1].valid <= 1'b0;
         end else if (adv) begin
            dv_ff[s+1].valid <= ctl.valid;
         end
         if (adv) begin
            dv_ff[s+1].zero <= ctl.zero;
         end
      end
   end

   for (genvar k = 0; k < AX; k++) begin : g_lane
      logic [MB-1:0] m;
      assign m = tag_out[k*(MB+1) +: MB];
      vnorm_div #(
         .NUM_BITS(NB),
         .DEN_BITS(RTB)
      ) u_div (
         .clock   (clock),
         .adv     (adv),
         .dividend({m, {FRACTION_BITS{1'b0}}}),
         .divisor (tag_out[TAGB-1] ? RTB'(1) : root),
         .negate  (tag_out[k*(MB+1) + MB]),
         .quotient(quo[k]),
         .neg_out (neg_q[k])
      );
   end

   // Merge lanes into the output register.
   logic [47:0] rsp_data_ff;
   logic [47:0] rsp_data_in;

   always_comb begin
      rsp_data_in = '0;
      for (int k = 0; k < AX; k++) begin
         logic [OB-1:0] q;
         q = OB'(quo[k]);
         if (dv_ff[NB].zero) begin
            rsp_data_in[k*OB +: OB] = '0;
         end else begin
            rsp_data_in[k*OB +: OB] = neg_q[k] ? OB'(~q + 1'b1) : q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_full_ff <= 1'b0;
      end else if (adv) begin
         out_full_ff <= dv_ff[NB].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = out_full_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/vnorm_checker.sv
// Port-level checker for the vector normalization unit, with its bind.
module vnorm_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   // Stalled result holds its value.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // Input is refused only while a result is stalled.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input refused without stall");

   // No result straight out of reset.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result after reset");

endmodule

bind vector3_normalise_unit vnorm_checker u_vnorm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
